[src/manifest_header_parser_assert.svh]
// ----------------------------------------------------------------------------
// Manifest header parser assertion macros
// Clocked property wrappers shared by the parser RTL.
// ----------------------------------------------------------------------------
`ifndef MANIFEST_HEADER_PARSER_ASSERT_SVH
`define MANIFEST_HEADER_PARSER_ASSERT_SVH

// Check a property on every clock edge outside of reset.
`define MHP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define MHP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[src/mhp_pkg.sv]
// ----------------------------------------------------------------------------
// Manifest header parser package
// Event codes, parser modes, character constants and the event record type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mhp_pkg;

  // Default width of the byte position counter
  localparam int unsigned OffsetBitsDef = 32;
  // Width of the offset field on the result port
  localparam int unsigned OffsetOutW    = 32;
  // Most events one input byte can cause
  localparam int unsigned MaxResults    = 5;
  localparam int unsigned CntW          = $clog2(MaxResults + 1);

  typedef logic [CntW-1:0] cnt_t;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_NAME_BYTE  = 3'd0,
    KIND_NAME_DONE  = 3'd1,
    KIND_VALUE_BYTE = 3'd2,
    KIND_HDR_END    = 3'd3,
    KIND_HDR_DROP   = 3'd4,
    KIND_SEC_END    = 3'd5,
    KIND_ERROR      = 3'd6,
    KIND_STREAM_END = 3'd7
  } kind_e;

  // Error codes
  typedef enum logic [1:0] {
    ERR_BAD_NAME = 2'd0,
    ERR_NO_SPACE = 2'd1,
    ERR_NUL      = 2'd2
  } err_e;

  // Parser modes, one-hot
  typedef enum logic [3:0] {
    MODE_NAME  = 4'b0001,
    MODE_COLON = 4'b0010,
    MODE_VALUE = 4'b0100,
    MODE_ERROR = 4'b1000
  } mode_e;

  // Characters of interest
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChUnder = 8'h5F;
  localparam logic [7:0] ChDash  = 8'h2D;
  localparam logic [7:0] ChNul   = 8'h00;

  // Line break counter saturates here
  localparam logic [1:0] BrkMax  = 2'd3;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  payload;
    err_e        err;
  } ev_t;

  // Build one event record
  function automatic ev_t mk_ev(kind_e kind, logic [7:0] payload, err_e err);
    ev_t e;
    e.kind    = kind;
    e.payload = payload;
    e.err     = err;
    return e;
  endfunction

  // Letters, digits, underscore and dash are legal in a header name
  function automatic logic is_name_char(logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) ||
           (b >= 8'h30 && b <= 8'h39) || b == ChUnder || b == ChDash;
  endfunction

endpackage

[src/manifest_header_parser.sv]
// Manifest header parser.
// Input channel: one manifest byte per request (data_byte_i, final_req_i),
// handshaked by in_valid_i / in_ready_o. Output channel: one event per
// request (kind_o, payload_o, error_code_o, offset_o, run_last_o), handshaked
// by out_valid_o / out_ready_i; run_last_o marks the last event of a byte.
// Each accepted byte is decoded in the accept cycle against the parser state,
// and its whole event list (0 to 5 events) is written into a result register
// bank. Events appear on the output the cycle after the accept.
// A byte causing k events holds the output until all k are taken; a byte
// causing one event or none can follow in the next cycle, so the sustained rate
// is one byte per cycle on ordinary header text while out_ready_i is high; the
// bank drains one event per cycle while ready and limits the rate at header ends.
// in_ready_o is high while the bank is empty or its last event leaves this
// cycle, so a stalled receiver stops the input after one pending byte.
// Reset returns to name parsing at offset 0 with no pending events; a byte
// flagged final emits its closing events and returns the parser to name
// parsing at offset 0.
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// manifest_header_parser
// Streaming decoder of manifest header names and values into events.
// ----------------------------------------------------------------------------
module manifest_header_parser
  import mhp_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = OffsetBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            data_byte_i,
  input  logic                  final_req_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [2:0]            kind_o,
  output logic [7:0]            payload_o,
  output logic [1:0]            error_code_o,
  output logic [OffsetOutW-1:0] offset_o,
  output logic                  run_last_o
);

  `include "manifest_header_parser_assert.svh"

  mode_e                  mode_q, mode_d;
  logic [1:0]             brk_q, brk_d;
  logic                   cr_q, cr_d;
  logic [OFFSET_BITS-1:0] pos_q, pos_d;
  logic [OFFSET_BITS-1:0] off_q;
  cnt_t                   cnt_q, cnt_d;
  ev_t                    ev_q [MaxResults];
  ev_t                    ev_d [MaxResults];
  ev_t                    ev_new [MaxResults];
  cnt_t                   n_new;
  logic                   do_name;
  logic                   in_acc;
  logic                   out_acc;

  // Handshake
  assign out_valid_o = (cnt_q != '0);
  assign out_acc     = out_valid_o && out_ready_i;
  assign in_ready_o  = (cnt_q == '0) || ((cnt_q == cnt_t'(1)) && out_ready_i);
  assign in_acc      = in_valid_i && in_ready_o;

  // Decode one byte into its event list and the next parser state
  always_comb begin
    mode_d  = mode_q;
    brk_d   = brk_q;
    cr_d    = cr_q;
    pos_d   = pos_q + OFFSET_BITS'(1);
    n_new   = '0;
    do_name = 1'b0;
    for (int i = 0; i < MaxResults; i++) begin
      ev_new[i] = mk_ev(KIND_NAME_BYTE, ChNul, ERR_BAD_NAME);
    end

    unique case (mode_q)
      MODE_NAME: begin
        do_name = 1'b1;
      end
      MODE_COLON: begin
        if (data_byte_i == ChSpace) begin
          mode_d = MODE_VALUE;
          brk_d  = '0;
          cr_d   = 1'b0;
        end else begin
          ev_new[n_new] = mk_ev(KIND_ERROR, ChNul, ERR_NO_SPACE);
          n_new         = n_new + cnt_t'(1);
          mode_d        = MODE_ERROR;
        end
      end
      MODE_VALUE: begin
        priority if (data_byte_i == ChNul) begin
          ev_new[n_new] = mk_ev(KIND_ERROR, ChNul, ERR_NUL);
          n_new         = n_new + cnt_t'(1);
          mode_d        = MODE_ERROR;
        end else if (data_byte_i == ChLf) begin
          // LF after CR closes the same break
          if (cr_q) begin
            cr_d = 1'b0;
          end else if (brk_q != BrkMax) begin
            brk_d = brk_q + 2'd1;
          end
        end else if (data_byte_i == ChCr) begin
          cr_d = 1'b1;
          if (brk_q != BrkMax) begin
            brk_d = brk_q + 2'd1;
          end
        end else if (data_byte_i == ChSpace && brk_q == 2'd1) begin
          // continuation line: drop the space
          brk_d = '0;
        end else if (brk_q != '0) begin
          ev_new[n_new] = mk_ev(KIND_HDR_END, ChNul, ERR_BAD_NAME);
          n_new         = n_new + cnt_t'(1);
          if (brk_q >= 2'd2) begin
            ev_new[n_new] = mk_ev(KIND_SEC_END, ChNul, ERR_BAD_NAME);
            n_new         = n_new + cnt_t'(1);
          end
          mode_d  = MODE_NAME;
          brk_d   = '0;
          cr_d    = 1'b0;
          do_name = 1'b1;
        end else begin
          ev_new[n_new] = mk_ev(KIND_VALUE_BYTE, data_byte_i, ERR_BAD_NAME);
          n_new         = n_new + cnt_t'(1);
        end
      end
      MODE_ERROR: begin
        // sticky: swallow bytes until the final one
      end
      default: begin
        mode_d = MODE_ERROR;
      end
    endcase

    // Name character handling
    if (do_name) begin
      priority if (data_byte_i == ChColon) begin
        ev_new[n_new] = mk_ev(KIND_NAME_DONE, ChNul, ERR_BAD_NAME);
        n_new         = n_new + cnt_t'(1);
        mode_d        = MODE_COLON;
      end else if (is_name_char(data_byte_i)) begin
        ev_new[n_new] = mk_ev(KIND_NAME_BYTE, data_byte_i, ERR_BAD_NAME);
        n_new         = n_new + cnt_t'(1);
      end else begin
        ev_new[n_new] = mk_ev(KIND_ERROR, ChNul, ERR_BAD_NAME);
        n_new         = n_new + cnt_t'(1);
        mode_d        = MODE_ERROR;
      end
    end

    // Close the buffer on the final byte
    if (final_req_i) begin
      unique case (mode_d)
        MODE_VALUE: begin
          ev_new[n_new] = mk_ev((brk_d != '0) ? KIND_HDR_END : KIND_HDR_DROP,
                                ChNul, ERR_BAD_NAME);
          n_new         = n_new + cnt_t'(1);
        end
        MODE_NAME: begin
          ev_new[n_new] = mk_ev(KIND_HDR_DROP, ChNul, ERR_BAD_NAME);
          n_new         = n_new + cnt_t'(1);
        end
        MODE_COLON: begin
          ev_new[n_new] = mk_ev(KIND_ERROR, ChNul, ERR_NO_SPACE);
          n_new         = n_new + cnt_t'(1);
        end
        default: begin
        end
      endcase
      ev_new[n_new] = mk_ev(KIND_STREAM_END, ChNul, ERR_BAD_NAME);
      n_new         = n_new + cnt_t'(1);
      mode_d        = MODE_NAME;
      brk_d         = '0;
      cr_d          = 1'b0;
      pos_d         = '0;
    end
  end

  // Result bank: load on accept, shift out on each taken request
  always_comb begin
    cnt_d = cnt_q;
    for (int i = 0; i < MaxResults; i++) begin
      ev_d[i] = ev_q[i];
    end
    if (in_acc) begin
      cnt_d = n_new;
      for (int i = 0; i < MaxResults; i++) begin
        ev_d[i] = ev_new[i];
      end
    end else if (out_acc) begin
      cnt_d = cnt_q - cnt_t'(1);
      for (int i = 0; i < MaxResults - 1; i++) begin
        ev_d[i] = ev_q[i+1];
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_NAME;
      brk_q  <= '0;
      cr_q   <= 1'b0;
      pos_q  <= '0;
      cnt_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (in_acc) begin
        mode_q <= mode_d;
        brk_q  <= brk_d;
        cr_q   <= cr_d;
        pos_q  <= pos_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxResults; i++) begin
      ev_q[i] <= ev_d[i];
    end
    if (in_acc) begin
      off_q <= pos_q;
    end
  end

  // Drive the result port from the head of the bank
  assign kind_o       = ev_q[0].kind;
  assign payload_o    = ev_q[0].payload;
  assign error_code_o = ev_q[0].err;
  assign offset_o     = OffsetOutW'(off_q);
  assign run_last_o   = (cnt_q == cnt_t'(1));

  // Checks
  `MHP_ASSERT(a_err_silent,
    in_acc && mode_q == MODE_ERROR && !final_req_i |=> !out_valid_o,
    "byte in error mode produced a result")
  `MHP_ASSERT(a_final_resets,
    in_acc && final_req_i |=> mode_q == MODE_NAME && pos_q == '0 && out_valid_o,
    "final byte did not restart the parser")
  `MHP_ASSERT(a_cnt_bound, cnt_q <= cnt_t'(MaxResults),
    "result bank count out of range")
  `MHP_ASSERT(a_mode_onehot, $onehot(mode_q),
    "parser mode lost one-hot encoding")

endmodule
